// ----- rtl/core/clws_pkg.sv -----
// Shared types and constants for the character LCD write sequencer.
// Holds the microcode word layout, step addresses, command bytes and hold codes.
// No dependencies.
package clws_pkg;

  localparam int MODE_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 6;
  localparam int HOLD_W    = 16;
  localparam int PC_W      = 6;
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CMD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHAR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEX    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CURSOR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINKING  = 2'd1;

  // LCD command bytes
  localparam logic [BYTE_W-1:0] CMD_FUNC_SET = 8'h3C;
  localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_ENTRY    = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;

  // Byte source select
  localparam logic [2:0] SEL_FUNC   = 3'd0;
  localparam logic [2:0] SEL_DISP   = 3'd1;
  localparam logic [2:0] SEL_CLR    = 3'd2;
  localparam logic [2:0] SEL_ENTRY  = 3'd3;
  localparam logic [2:0] SEL_VAL    = 3'd4;
  localparam logic [2:0] SEL_HEX_HI = 3'd5;
  localparam logic [2:0] SEL_HEX_LO = 3'd6;
  localparam logic [2:0] SEL_CURSOR = 3'd7;

  // Hold time codes
  localparam logic [1:0] HLD_POWER = 2'd0;
  localparam logic [1:0] HLD_CLEAR = 2'd1;
  localparam logic [1:0] HLD_SETUP = 2'd2;
  localparam logic [1:0] HLD_PULSE = 2'd3;

  localparam logic [HOLD_W-1:0] US_POWER = 16'd40000;
  localparam logic [HOLD_W-1:0] US_CLEAR = 16'd1520;
  localparam logic [HOLD_W-1:0] US_SETUP = 16'd100;
  localparam logic [HOLD_W-1:0] US_PULSE = 16'd50;

  // Program entry points
  localparam logic [PC_W-1:0] PC_INIT   = 6'd0;
  localparam logic [PC_W-1:0] PC_CMD    = 6'd26;
  localparam logic [PC_W-1:0] PC_CHAR   = 6'd30;
  localparam logic [PC_W-1:0] PC_HEX    = 6'd34;
  localparam logic [PC_W-1:0] PC_CURSOR = 6'd42;
  localparam logic [PC_W-1:0] PC_CLEAR  = 6'd46;

  // One control word per emitted phase
  typedef struct packed {
    logic       en;    // enable pin level
    logic       load;  // latch rs/byte in this phase
    logic       rs;    // rs level to latch
    logic [2:0] sel;   // byte source
    logic [1:0] hold;  // hold code
    logic       last;  // final phase of the request
  } ucode_t;

endpackage

// ----- rtl/core/clws_ucode_rom.sv -----
// Microcode table of the LCD write sequencer: one control word per step.
// Depends on clws_pkg.
module clws_ucode_rom (
  input  logic [clws_pkg::PC_W-1:0] pc,
  output clws_pkg::ucode_t          word
);
  import clws_pkg::*;

  // One of the four phases of a byte write
  function automatic ucode_t byte_ph(input logic [1:0] ph, input logic [2:0] sel,
                                     input logic rs, input logic last);
    ucode_t w;
    w.en   = (ph == 2'd2);
    w.load = (ph == 2'd1);
    w.rs   = rs;
    w.sel  = sel;
    w.hold = (ph[1] == 1'b0) ? HLD_SETUP : HLD_PULSE;
    w.last = last && (ph == 2'd3);
    return w;
  endfunction

  // Pins unchanged, enable low
  function automatic ucode_t wait_ph(input logic [1:0] hold, input logic last);
    ucode_t w;
    w.en   = 1'b0;
    w.load = 1'b0;
    w.rs   = 1'b0;
    w.sel  = SEL_VAL;
    w.hold = hold;
    w.last = last;
    return w;
  endfunction

  always_comb begin
    case (pc)
      6'd0:                    word = wait_ph(HLD_POWER, 1'b0);
      6'd1, 6'd2, 6'd3, 6'd4:  word = byte_ph(2'(pc - 6'd1), SEL_FUNC, 1'b0, 1'b0);
      6'd5:                    word = wait_ph(HLD_SETUP, 1'b0);
      6'd6, 6'd7, 6'd8, 6'd9:  word = byte_ph(2'(pc - 6'd6), SEL_FUNC, 1'b0, 1'b0);
      6'd10:                   word = wait_ph(HLD_SETUP, 1'b0);
      6'd11, 6'd12, 6'd13, 6'd14:
                               word = byte_ph(2'(pc - 6'd11), SEL_DISP, 1'b0, 1'b0);
      6'd15:                   word = wait_ph(HLD_SETUP, 1'b0);
      6'd16, 6'd17, 6'd18, 6'd19:
                               word = byte_ph(2'(pc - 6'd16), SEL_CLR, 1'b0, 1'b0);
      6'd20:                   word = wait_ph(HLD_CLEAR, 1'b0);
      6'd21, 6'd22, 6'd23, 6'd24:
                               word = byte_ph(2'(pc - 6'd21), SEL_ENTRY, 1'b0, 1'b0);
      6'd25:                   word = wait_ph(HLD_CLEAR, 1'b1);
      6'd26, 6'd27, 6'd28, 6'd29:
                               word = byte_ph(2'(pc - PC_CMD), SEL_VAL, 1'b0, 1'b1);
      6'd30, 6'd31, 6'd32, 6'd33:
                               word = byte_ph(2'(pc - PC_CHAR), SEL_VAL, 1'b1, 1'b1);
      6'd34, 6'd35, 6'd36, 6'd37:
                               word = byte_ph(2'(pc - PC_HEX), SEL_HEX_HI, 1'b1, 1'b0);
      6'd38, 6'd39, 6'd40, 6'd41:
                               word = byte_ph(2'(pc - 6'd38), SEL_HEX_LO, 1'b1, 1'b1);
      6'd42, 6'd43, 6'd44, 6'd45:
                               word = byte_ph(2'(pc - PC_CURSOR), SEL_CURSOR, 1'b0, 1'b1);
      6'd46, 6'd47, 6'd48, 6'd49:
                               word = byte_ph(2'(pc - PC_CLEAR), SEL_CLR, 1'b0, 1'b0);
      6'd50:                   word = wait_ph(HLD_CLEAR, 1'b1);
      default:                 word = wait_ph(HLD_SETUP, 1'b1);
    endcase
  end

endmodule

// ----- rtl/core/char_lcd_write_sequencer_core.sv -----
// Character LCD write sequencer: turns requests into timed 8-bit bus phases.
// The accepted request loads the step counter, which walks the microcode ROM; each phase
// is registered into the output payload registers. One phase per cycle while the output is
// not stalled; 4, 5, 8 or 26 phases per request. New requests are stalled until the last
// phase is emitted. Output stall freezes the step counter.
// Reset (sync, rst_n low): idle, no phase pending, RS/bus levels and options zero.
module char_lcd_write_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [clws_pkg::MODE_W-1:0]     in_mode,
  input  logic [clws_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic                            in_line_select,
  input  logic [clws_pkg::COL_W-1:0]      in_column,
  // phase channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_reg_select,
  output logic                            out_read_write,
  output logic [clws_pkg::BYTE_W-1:0]     out_data_bus,
  output logic                            out_enable_pin,
  output logic [clws_pkg::HOLD_W-1:0]     out_hold_us,
  output logic                            out_last_phase,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                            cfg_data
);
  import clws_pkg::*;

  // control state
  logic              busy_r, busy_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              out_valid_r, out_valid_nxt;
  // pin state that persists across requests
  logic              rs_r, rs_nxt;
  logic [BYTE_W-1:0] bus_r, bus_nxt;
  // options
  logic              cursor_on_r, blinking_r;
  // captured request fields
  logic [BYTE_W-1:0] val_r;
  logic              line_r;
  logic [COL_W-1:0]  col_r;
  // output payload
  logic              o_rs_r, o_en_r, o_last_r;
  logic [BYTE_W-1:0] o_bus_r;
  logic [HOLD_W-1:0] o_hold_r;

  ucode_t            word;
  logic              in_fire, mode_ok, emit;
  logic [PC_W-1:0]   entry_pc;
  logic [BYTE_W-1:0] sel_byte, ph_bus;
  logic              ph_rs;
  logic [HOLD_W-1:0] ph_hold;

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else             c = 8'h37 + {4'd0, nib};
    return c;
  endfunction

  clws_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  // Requests only while the program is idle; unknown modes are taken and dropped.
  assign in_stall  = busy_r;
  assign in_fire   = in_valid && !in_stall;
  assign mode_ok   = in_mode inside {[MODE_INIT:MODE_CLEAR]};
  assign cfg_ready = 1'b1;

  always_comb begin
    case (in_mode)
      MODE_INIT:   entry_pc = PC_INIT;
      MODE_CMD:    entry_pc = PC_CMD;
      MODE_CHAR:   entry_pc = PC_CHAR;
      MODE_HEX:    entry_pc = PC_HEX;
      MODE_CURSOR: entry_pc = PC_CURSOR;
      MODE_CLEAR:  entry_pc = PC_CLEAR;
      default:     entry_pc = PC_INIT;
    endcase
  end

  // byte source for load steps
  always_comb begin
    case (word.sel)
      SEL_FUNC:   sel_byte = CMD_FUNC_SET;
      SEL_DISP:   sel_byte = CMD_DISP_ON | {6'd0, cursor_on_r, blinking_r};
      SEL_CLR:    sel_byte = CMD_CLEAR;
      SEL_ENTRY:  sel_byte = CMD_ENTRY;
      SEL_VAL:    sel_byte = val_r;
      SEL_HEX_HI: sel_byte = hex_char(val_r[7:4]);
      SEL_HEX_LO: sel_byte = hex_char(val_r[3:0]);
      SEL_CURSOR: sel_byte = CMD_SET_ADDR | {1'b0, line_r, col_r};
      default:    sel_byte = val_r;
    endcase
  end

  always_comb begin
    case (word.hold)
      HLD_POWER: ph_hold = US_POWER;
      HLD_CLEAR: ph_hold = US_CLEAR;
      HLD_SETUP: ph_hold = US_SETUP;
      HLD_PULSE: ph_hold = US_PULSE;
      default:   ph_hold = US_SETUP;
    endcase
  end

  // a load step drives the new levels in the same phase it latches them
  assign ph_rs  = word.load ? word.rs : rs_r;
  assign ph_bus = word.load ? sel_byte : bus_r;

  // step whenever the output register is free or drains this cycle
  assign emit = busy_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    rs_nxt        = rs_r;
    bus_nxt       = bus_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      rs_nxt        = ph_rs;
      bus_nxt       = ph_bus;
      pc_nxt        = pc_r + 6'd1;
      if (word.last) begin
        busy_nxt = 1'b0;
      end
    end else if (in_fire && mode_ok) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_INIT;
      out_valid_r <= 1'b0;
      rs_r        <= 1'b0;
      bus_r       <= '0;
      cursor_on_r <= 1'b0;
      blinking_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      rs_r        <= rs_nxt;
      bus_r       <= bus_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CURSOR_ON) cursor_on_r <= cfg_data;
        if (cfg_index == CFG_BLINKING)  blinking_r  <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r  <= in_byte_value;
      line_r <= in_line_select;
      col_r  <= in_column;
    end
    if (emit) begin
      o_rs_r   <= ph_rs;
      o_bus_r  <= ph_bus;
      o_en_r   <= word.en;
      o_hold_r <= ph_hold;
      o_last_r <= word.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = o_rs_r;
  assign out_read_write = 1'b0;
  assign out_data_bus   = o_bus_r;
  assign out_enable_pin = o_en_r;
  assign out_hold_us    = o_hold_r;
  assign out_last_phase = o_last_r;

`ifndef ASSERT_OFF
  // a valid request starts the program
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_ok) |=> busy_r)
    else $error("valid request did not start the sequencer");

  // the last step ends the program
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && word.last) |=> !busy_r)
    else $error("sequencer kept running after last phase");

  // enable pulses are always the short hold
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_enable_pin) |-> (out_hold_us == US_PULSE))
    else $error("enable high with wrong hold time");

  // a finished phase is never overwritten while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(o_bus_r) && $stable(o_hold_r)))
    else $error("stalled phase was overwritten");
`endif

endmodule
